### hw/rtl/hashed_gaussian_noise_generator_top_defines.svh
// Assertion macros for the hashed Gaussian noise generator.
`ifndef HASHED_GAUSSIAN_NOISE_GENERATOR_TOP_DEFINES_SVH
`define HASHED_GAUSSIAN_NOISE_GENERATOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define HGN_ASSERT_IMP(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("hgn: assertion failed");
`define HGN_ASSERT_NXT(lbl, clk, rst_n, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("hgn: assertion failed");
`else
`define HGN_ASSERT_IMP(lbl, clk, rst_n, ant, con)
`define HGN_ASSERT_NXT(lbl, clk, rst_n, ant, con)
`endif

`endif

### hw/rtl/hgn_pkg.sv
// Shared types and constants of the hashed Gaussian noise generator.
`default_nettype none
package hgn_pkg;

  localparam int COORD_W = 8;
  localparam int OPND_W  = 9;
  localparam int N_HASH  = 4;

  localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
  localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
  localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
  localparam logic [31:0] FRAC_FLOOR   = 32'd4295;
  localparam logic [30:0] TWO_LN2_Q30  = 31'd1488522236;
  localparam logic [32:0] HALF_PI_Q32  = 33'd6746518852;

  localparam logic [OPND_W-1:0] OFF_X [N_HASH] = '{9'd0, 9'd57, 9'd91, 9'd13};
  localparam logic [OPND_W-1:0] OFF_Y [N_HASH] = '{9'd0, 9'd131, 9'd7, 9'd199};

  localparam int TERM_N = 6;
  localparam logic [7:0] DIV_C [TERM_N] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};
  localparam logic [7:0] DIV_S [TERM_N] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [31:0] RCP_C [TERM_N] = '{
    32'((64'd1 << 32) / 64'd2),  32'((64'd1 << 32) / 64'd12),
    32'((64'd1 << 32) / 64'd30), 32'((64'd1 << 32) / 64'd56),
    32'((64'd1 << 32) / 64'd90), 32'((64'd1 << 32) / 64'd132)};
  localparam logic [31:0] RCP_S [TERM_N] = '{
    32'((64'd1 << 32) / 64'd6),  32'((64'd1 << 32) / 64'd20),
    32'((64'd1 << 32) / 64'd42), 32'((64'd1 << 32) / 64'd72),
    32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd156)};

  localparam int SQ_N = 24;
  localparam int RT_N = 27;
  localparam int T_W  = 30;
  localparam int RT_FEED = T_W / 2;

  localparam int HASH_LAT = 2;
  localparam int RAD_LAT  = 1 + SQ_N + 2 + RT_N;
  localparam int TRIG_LAT = 3 + 3 * TERM_N + 1;
  localparam int TRIG_DLY = RAD_LAT - TRIG_LAT;
  localparam int PIPE_LAT = HASH_LAT + RAD_LAT + 1;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = 1;
  localparam int Q_CNT_W = 2;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } coord_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

### hw/rtl/hgn_queue.sv
// Two-word coordinate queue between the accept side and the compute pipeline.
`default_nettype none
module hgn_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hgn_pkg::coord_t  data_i,
  input  logic             pop_i,
  output hgn_pkg::coord_t  data_o,
  output hgn_pkg::q_stat_t stat_o
);
  hgn_pkg::coord_t mem_q [hgn_pkg::Q_DEPTH];
  logic [hgn_pkg::Q_PTR_W-1:0] wr_q, rd_q;
  logic [hgn_pkg::Q_CNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  assign data_o       = mem_q[rd_q];
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.full  = (cnt_q == hgn_pkg::Q_CNT_W'(hgn_pkg::Q_DEPTH));
endmodule
`default_nettype wire

### hw/rtl/hgn_hash.sv
// Two-stage 32-bit integer hash of an offset coordinate pair.
`default_nettype none
module hgn_hash (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [hgn_pkg::OPND_W-1:0] a_i,
  input  logic [hgn_pkg::OPND_W-1:0] b_i,
  output logic [31:0]                hash_o
);
  logic [40:0] pa, pb;
  logic [31:0] sum_d, sum_q, pre, mix_d, mix_q;
  logic [63:0] pm;

  always_comb begin
    pa    = 41'(a_i) * 41'(hgn_pkg::HASH_MUL_X);
    pb    = 41'(b_i) * 41'(hgn_pkg::HASH_MUL_Y);
    sum_d = pa[31:0] + pb[31:0];
    pre   = sum_q ^ (sum_q >> 13);
    pm    = 64'(pre) * 64'(hgn_pkg::HASH_MUL_MIX);
    mix_d = pm[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_q <= sum_d;
      mix_q <= mix_d;
    end
  end

  assign hash_o = mix_q ^ (mix_q >> 16);
endmodule
`default_nettype wire

### hw/rtl/hgn_radius.sv
// Radius sqrt(-2 ln u) in Q.24: normalize, log2 by squaring, scale, digit-serial root.
`default_nettype none
module hgn_radius (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [31:0]              hash_i,
  output logic [hgn_pkg::RT_N-1:0] rad_o
);
  logic [31:0] hc, z0_d, z0_q;
  logic [4:0]  lz_d, lz0_q;

  logic [31:0] z_q   [hgn_pkg::SQ_N];
  logic [23:0] fr_q  [hgn_pkg::SQ_N];
  logic [4:0]  lzp_q [hgn_pkg::SQ_N];

  logic [4:0]  lz1;
  logic [28:0] lg_d, lg_q;
  logic [59:0] tp;
  logic [hgn_pkg::T_W-1:0] t_q;

  logic [28:0]               rem_q  [hgn_pkg::RT_N];
  logic [hgn_pkg::RT_N-1:0]  root_q [hgn_pkg::RT_N];
  logic [hgn_pkg::T_W-1:0]   tt_q   [hgn_pkg::RT_N];

  always_comb begin
    hc   = (hash_i < hgn_pkg::FRAC_FLOOR) ? hgn_pkg::FRAC_FLOOR : hash_i;
    lz_d = '0;
    for (int i = 0; i < 32; i++) begin
      if (hc[i]) begin
        lz_d = 5'(31 - i);
      end
    end
    z0_d = hc << lz_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q  <= z0_d;
      lz0_q <= lz_d;
    end
  end

  for (genvar k = 0; k < hgn_pkg::SQ_N; k++) begin : g_sq
    logic [31:0] zin;
    logic [23:0] fin;
    logic [4:0]  lin;
    logic [63:0] sq;
    logic [32:0] zs;
    if (k == 0) begin : g_first
      assign zin = z0_q;
      assign fin = '0;
      assign lin = lz0_q;
    end else begin : g_next
      assign zin = z_q[k-1];
      assign fin = fr_q[k-1];
      assign lin = lzp_q[k-1];
    end
    assign sq = 64'(zin) * 64'(zin);
    assign zs = sq[63:31];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        z_q[k]   <= zs[32] ? zs[32:1] : zs[31:0];
        fr_q[k]  <= fin | ({23'd0, zs[32]} << (hgn_pkg::SQ_N - 1 - k));
        lzp_q[k] <= lin;
      end
    end
  end

  always_comb begin
    lz1  = lzp_q[hgn_pkg::SQ_N-1] + 5'd1;
    lg_d = {lz1, 24'd0} - {5'd0, fr_q[hgn_pkg::SQ_N-1]};
    tp   = 60'(lg_q) * 60'(hgn_pkg::TWO_LN2_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lg_q <= lg_d;
      t_q  <= tp[59:30];
    end
  end

  for (genvar i = 0; i < hgn_pkg::RT_N; i++) begin : g_rt
    logic [28:0]              rin;
    logic [hgn_pkg::RT_N-1:0] oin;
    logic [hgn_pkg::T_W-1:0]  tin;
    logic [1:0]               dig;
    logic [30:0]              rn, trial;
    logic                     ge;
    if (i == 0) begin : g_first
      assign rin = '0;
      assign oin = '0;
      assign tin = t_q;
    end else begin : g_next
      assign rin = rem_q[i-1];
      assign oin = root_q[i-1];
      assign tin = tt_q[i-1];
    end
    if (i < hgn_pkg::RT_FEED) begin : g_feed
      assign dig = tin[hgn_pkg::T_W-1-2*i -: 2];
    end else begin : g_zero
      assign dig = 2'b00;
    end
    assign rn    = {rin, dig};
    assign trial = {3'b000, oin[hgn_pkg::RT_N-2:0], 2'b01};
    assign ge    = (rn >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? 29'(rn - trial) : 29'(rn);
        root_q[i] <= {oin[hgn_pkg::RT_N-2:0], ge};
        tt_q[i]   <= tin;
      end
    end
  end

  assign rad_o = root_q[hgn_pkg::RT_N-1];
endmodule
`default_nettype wire

### hw/rtl/hgn_sincos.sv
// Pipelined octant-reduced Taylor sine or cosine of 2 pi p / 2^32 in Q2.30.
`default_nettype none
module hgn_sincos (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        phase_i,
  input  logic               sine_i,
  output logic signed [31:0] trig_o
);
  typedef struct packed {
    logic [1:0]         quad;
    logic               sw;
    logic [29:0]        x2;
    logic signed [31:0] c;
    logic signed [31:0] s;
  } sc_ctx_t;

  logic [29:0] r_raw, r_d, r_a, x_b, x_c;
  logic [1:0]  quad_a, quad_b, quad_c;
  logic        sw_d, sw_a, sw_b, sw_c;
  logic [62:0] px;
  logic [59:0] pxx;
  logic [29:0] x2_c;

  logic [30:0] ncm_q [hgn_pkg::TERM_N];
  logic [30:0] nsm_q [hgn_pkg::TERM_N];
  sc_ctx_t     cxm_q [hgn_pkg::TERM_N];
  logic [30:0] qcr_q [hgn_pkg::TERM_N];
  logic [30:0] qsr_q [hgn_pkg::TERM_N];
  logic [30:0] ncr_q [hgn_pkg::TERM_N];
  logic [30:0] nsr_q [hgn_pkg::TERM_N];
  sc_ctx_t     cxr_q [hgn_pkg::TERM_N];
  logic [30:0] tc_q  [hgn_pkg::TERM_N];
  logic [30:0] ts_q  [hgn_pkg::TERM_N];
  sc_ctx_t     cxc_q [hgn_pkg::TERM_N];

  logic signed [31:0] ca, sa, cos_v, sin_v;
  sc_ctx_t            last;

  always_comb begin
    r_raw = phase_i[29:0];
    sw_d  = (r_raw >= 30'h2000_0000);
    r_d   = sw_d ? 30'(31'h4000_0000 - 31'(r_raw)) : r_raw;
    px    = 63'(r_a) * 63'(hgn_pkg::HALF_PI_Q32);
    pxx   = 60'(x_b) * 60'(x_b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quad_a <= phase_i[31:30];
      sw_a   <= sw_d;
      r_a    <= r_d;
      quad_b <= quad_a;
      sw_b   <= sw_a;
      x_b    <= px[61:32];
      quad_c <= quad_b;
      sw_c   <= sw_b;
      x_c    <= x_b;
      x2_c   <= pxx[59:30];
    end
  end

  for (genvar n = 0; n < hgn_pkg::TERM_N; n++) begin : g_term
    logic [30:0] tci, tsi;
    sc_ctx_t     cxi, cxo;
    logic [60:0] pc, ps;
    logic [62:0] rc, rs;
    logic [38:0] mc, ms, ec, es;
    logic [30:0] tcn, tsn;
    if (n == 0) begin : g_first
      assign tci      = 31'h4000_0000;
      assign tsi      = {1'b0, x_c};
      assign cxi.quad = quad_c;
      assign cxi.sw   = sw_c;
      assign cxi.x2   = x2_c;
      assign cxi.c    = 32'sh4000_0000;
      assign cxi.s    = $signed({2'b00, x_c});
    end else begin : g_next
      assign tci = tc_q[n-1];
      assign tsi = ts_q[n-1];
      assign cxi = cxc_q[n-1];
    end
    assign pc  = 61'(tci) * 61'(cxi.x2);
    assign ps  = 61'(tsi) * 61'(cxi.x2);
    assign rc  = 63'(ncm_q[n]) * 63'(hgn_pkg::RCP_C[n]);
    assign rs  = 63'(nsm_q[n]) * 63'(hgn_pkg::RCP_S[n]);
    assign mc  = 39'(qcr_q[n]) * 39'(hgn_pkg::DIV_C[n]);
    assign ms  = 39'(qsr_q[n]) * 39'(hgn_pkg::DIV_S[n]);
    assign ec  = 39'(ncr_q[n]) - mc;
    assign es  = 39'(nsr_q[n]) - ms;
    assign tcn = qcr_q[n] + 31'(ec >= 39'(hgn_pkg::DIV_C[n]));
    assign tsn = qsr_q[n] + 31'(es >= 39'(hgn_pkg::DIV_S[n]));
    always_comb begin
      cxo = cxr_q[n];
      if ((n % 2) == 0) begin
        cxo.c = cxr_q[n].c - $signed({1'b0, tcn});
        cxo.s = cxr_q[n].s - $signed({1'b0, tsn});
      end else begin
        cxo.c = cxr_q[n].c + $signed({1'b0, tcn});
        cxo.s = cxr_q[n].s + $signed({1'b0, tsn});
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        ncm_q[n] <= pc[60:30];
        nsm_q[n] <= ps[60:30];
        cxm_q[n] <= cxi;
        qcr_q[n] <= rc[62:32];
        qsr_q[n] <= rs[62:32];
        ncr_q[n] <= ncm_q[n];
        nsr_q[n] <= nsm_q[n];
        cxr_q[n] <= cxm_q[n];
        tc_q[n]  <= tcn;
        ts_q[n]  <= tsn;
        cxc_q[n] <= cxo;
      end
    end
  end

  always_comb begin
    last = cxc_q[hgn_pkg::TERM_N-1];
    ca   = last.sw ? last.s : last.c;
    sa   = last.sw ? last.c : last.s;
    case (last.quad)
      2'd0: begin
        cos_v = ca;
        sin_v = sa;
      end
      2'd1: begin
        cos_v = -sa;
        sin_v = ca;
      end
      2'd2: begin
        cos_v = -ca;
        sin_v = -sa;
      end
      default: begin
        cos_v = sa;
        sin_v = -ca;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      trig_o <= sine_i ? sin_v : cos_v;
    end
  end
endmodule
`default_nettype wire

### hw/rtl/hashed_gaussian_noise_generator_top.sv
// Top level of the hashed Gaussian noise generator: queue, hash, radius, trig, output.
// Throughput: one word per cycle while the output is not stalled; every unit is fully pipelined, the radius
// path (54 stages) sets the depth and the trig values wait in a delay line.
// An output stall while an output word is valid freezes the whole pipeline; a two-word queue absorbs input words.
// Reset clears the queue pointers, the queue count and the valid bits only; no clearing pass.
`default_nettype none
`include "hashed_gaussian_noise_generator_top_defines.svh"
module hashed_gaussian_noise_generator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hgn_pkg::COORD_W-1:0] coord_x_i,
  input  logic [hgn_pkg::COORD_W-1:0] coord_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [15:0]          noise_cos_o,
  output logic signed [15:0]          noise_sin_o
);
  function automatic logic [15:0] to_q12(input logic [57:0] prod, input logic neg);
    logic [58:0] rnd;
    logic [16:0] q;
    logic [15:0] m;
    rnd = 59'(prod) + (59'd1 << 41);
    q   = rnd[58:42];
    m   = (q > 17'd32767) ? 16'h7fff : q[15:0];
    return neg ? 16'(~m + 16'd1) : m;
  endfunction

  hgn_pkg::coord_t  in_word, head;
  hgn_pkg::q_stat_t q_stat;
  logic             push, pop, pipe_en;

  logic [hgn_pkg::PIPE_LAT-1:0] vld_q;
  logic                         out_valid_q;
  logic [15:0]                  cos_q, sin_q;

  logic [31:0]              hash [hgn_pkg::N_HASH];
  logic [hgn_pkg::RT_N-1:0] rad1, rad3;
  logic signed [31:0]       trig_c, trig_s;
  logic signed [31:0]       dly_c_q [hgn_pkg::TRIG_DLY];
  logic signed [31:0]       dly_s_q [hgn_pkg::TRIG_DLY];
  logic signed [31:0]       tc_end, ts_end;
  logic                     neg_c, neg_s, neg_c_q, neg_s_q;
  logic [30:0]              mag_c, mag_s;
  logic [57:0]              prod_c_q, prod_s_q;

  assign in_word.x = coord_x_i;
  assign in_word.y = coord_y_i;
  assign push      = in_valid_i && !q_stat.full;
  assign pipe_en   = !out_valid_q || !out_stall_i;
  assign pop       = pipe_en && !q_stat.empty;

  hgn_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (in_word),
    .pop_i  (pop),
    .data_o (head),
    .stat_o (q_stat)
  );

  for (genvar i = 0; i < hgn_pkg::N_HASH; i++) begin : g_hash
    hgn_hash u_hash (
      .clk_i  (clk_i),
      .en_i   (pipe_en),
      .a_i    (hgn_pkg::OPND_W'(head.x) + hgn_pkg::OFF_X[i]),
      .b_i    (hgn_pkg::OPND_W'(head.y) + hgn_pkg::OFF_Y[i]),
      .hash_o (hash[i])
    );
  end

  hgn_radius u_rad1 (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .hash_i (hash[0]),
    .rad_o  (rad1)
  );

  hgn_radius u_rad3 (
    .clk_i  (clk_i),
    .en_i   (pipe_en),
    .hash_i (hash[2]),
    .rad_o  (rad3)
  );

  hgn_sincos u_cos2 (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .phase_i (hash[1]),
    .sine_i  (1'b0),
    .trig_o  (trig_c)
  );

  hgn_sincos u_sin4 (
    .clk_i   (clk_i),
    .en_i    (pipe_en),
    .phase_i (hash[3]),
    .sine_i  (1'b1),
    .trig_o  (trig_s)
  );

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dly_c_q[0] <= trig_c;
      dly_s_q[0] <= trig_s;
      for (int i = 1; i < hgn_pkg::TRIG_DLY; i++) begin
        dly_c_q[i] <= dly_c_q[i-1];
        dly_s_q[i] <= dly_s_q[i-1];
      end
    end
  end

  always_comb begin
    tc_end = dly_c_q[hgn_pkg::TRIG_DLY-1];
    ts_end = dly_s_q[hgn_pkg::TRIG_DLY-1];
    neg_c  = tc_end[31];
    neg_s  = ts_end[31];
    mag_c  = neg_c ? 31'(-tc_end) : tc_end[30:0];
    mag_s  = neg_s ? 31'(-ts_end) : ts_end[30:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      prod_c_q <= 58'(rad1) * 58'(mag_c);
      prod_s_q <= 58'(rad3) * 58'(mag_s);
      neg_c_q  <= neg_c;
      neg_s_q  <= neg_s;
      cos_q    <= to_q12(prod_c_q, neg_c_q);
      sin_q    <= to_q12(prod_s_q, neg_s_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      vld_q       <= {vld_q[hgn_pkg::PIPE_LAT-2:0], pop};
      out_valid_q <= vld_q[hgn_pkg::PIPE_LAT-1];
    end
  end

  assign in_stall_o  = q_stat.full;
  assign out_valid_o = out_valid_q;
  assign noise_cos_o = $signed(cos_q);
  assign noise_sin_o = $signed(sin_q);

  `HGN_ASSERT_NXT(a_pop_loads, clk_i, rst_ni, pipe_en && !q_stat.empty, vld_q[0])
  `HGN_ASSERT_NXT(a_stall_holds, clk_i, rst_ni, !pipe_en, $stable(vld_q) && out_valid_q)
  `HGN_ASSERT_NXT(a_drain, clk_i, rst_ni, pipe_en && vld_q[hgn_pkg::PIPE_LAT-1], out_valid_q)
endmodule
`default_nettype wire
